// ----- rtl/core/pat_pkg.sv -----
// Shared types and constants for the positional array table.
`default_nettype none

package pat_pkg;

    localparam int FIELD_W = 7;

    localparam logic [2:0] REQ_DUMP   = 3'd0;
    localparam logic [2:0] REQ_SEARCH = 3'd1;
    localparam logic [2:0] REQ_UPDATE = 3'd2;
    localparam logic [2:0] REQ_INSERT = 3'd3;
    localparam logic [2:0] REQ_DELETE = 3'd4;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [FIELD_W-1:0] slot;
        logic [FIELD_W-1:0] mark_in;
    } pat_req_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] where;
        logic [FIELD_W-1:0] mark_out;
        logic [FIELD_W-1:0] fill;
        logic               last;
    } pat_rsp_t;

    typedef struct packed {
        logic capture;
        logic decide;
        logic write_upd;
        logic start_scan;
        logic start_ins;
        logic start_del;
        logic scan_step;
        logic ins_step;
        logic del_step;
        logic report;
    } pat_cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       ok;
        logic       empty;
        logic       scan_done;
        logic       ins_done;
        logic       del_done;
        logic       out_free;
    } pat_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pat_datapath.sv -----
// Datapath: entry memory, fill count, walk pointer and response register.
`default_nettype none

module pat_datapath
    import pat_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire pat_req_t req_in,
    input  wire pat_cmd_t cmd,
    output pat_sts_t      sts,
    input  wire logic     rsp_ready,
    output logic          rsp_valid,
    output pat_rsp_t      rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > FIELD_W) ? CW : FIELD_W) + 1;

    logic [FIELD_W-1:0] mem [DEPTH];

    pat_req_t           req_reg;
    logic               ok_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      tag_reg, tag_next;
    logic               rd_valid_reg, rd_valid_next;
    logic [FIELD_W-1:0] rdata_reg;
    logic               hit_valid_reg, hit_valid_next;
    logic [CW-1:0]      hit_idx_reg, hit_idx_next;
    pat_rsp_t           rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               we, re, out_free, rsp_load, ok;
    logic [AW-1:0]      waddr, raddr;
    logic [FIELD_W-1:0] wdata;
    logic [XW-1:0]      cnt_x, slot_x, idx_x, tag_x;
    logic               scan_issue, ins_issue, del_issue;
    logic               upd_ok, ins_ok, del_ok;

    assign cnt_x  = XW'(count_reg);
    assign slot_x = XW'(req_reg.slot);
    assign idx_x  = XW'(idx_reg);
    assign tag_x  = XW'(tag_reg);

    assign upd_ok = slot_x < cnt_x;
    assign ins_ok = (cnt_x < XW'(DEPTH)) && (slot_x != '0) && (slot_x <= cnt_x + XW'(1));
    assign del_ok = (cnt_x != '0) && (slot_x != '0) && (slot_x <= cnt_x);

    always_comb
    begin
        unique case (req_reg.req_type)
            REQ_UPDATE: ok = upd_ok;
            REQ_INSERT: ok = ins_ok;
            REQ_DELETE: ok = del_ok;
            default:    ok = 1'b0;
        endcase
    end

    assign scan_issue = idx_x < cnt_x;
    assign ins_issue  = idx_x >= slot_x;
    assign del_issue  = (idx_x + XW'(1)) < cnt_x;
    assign out_free   = !rsp_valid_reg || rsp_ready;

    assign sts.req_type  = req_reg.req_type;
    assign sts.ok        = ok;
    assign sts.empty     = (count_reg == '0);
    assign sts.scan_done = !scan_issue && !rd_valid_reg;
    assign sts.ins_done  = !ins_issue && !rd_valid_reg;
    assign sts.del_done  = !del_issue && !rd_valid_reg;
    assign sts.out_free  = out_free;

    always_comb
    begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        tag_next       = tag_reg;
        rd_valid_next  = rd_valid_reg;
        hit_valid_next = hit_valid_reg;
        hit_idx_next   = hit_idx_reg;
        rsp_next       = rsp_reg;
        rsp_load       = 1'b0;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;
        re             = 1'b0;
        raddr          = '0;

        if (cmd.write_upd)
        begin
            we    = 1'b1;
            waddr = AW'(req_reg.slot);
            wdata = req_reg.mark_in;
        end

        if (cmd.start_scan)
        begin
            idx_next       = '0;
            rd_valid_next  = 1'b0;
            hit_valid_next = 1'b0;
        end

        if (cmd.start_ins)
        begin
            idx_next      = count_reg;
            rd_valid_next = 1'b0;
        end

        if (cmd.start_del)
        begin
            idx_next      = CW'(req_reg.slot - FIELD_W'(1));
            rd_valid_next = 1'b0;
        end

        if (cmd.scan_step && out_free)
        begin
            if (rd_valid_reg)
            begin
                if (req_reg.req_type == REQ_DUMP)
                begin
                    rsp_load          = 1'b1;
                    rsp_next.status   = 1'b0;
                    rsp_next.where    = FIELD_W'(tag_reg);
                    rsp_next.mark_out = rdata_reg;
                    rsp_next.fill     = FIELD_W'(count_reg);
                    rsp_next.last     = (tag_x + XW'(1)) == cnt_x;
                end
                else if (rdata_reg == req_reg.mark_in)
                begin
                    if (hit_valid_reg)
                    begin
                        rsp_load          = 1'b1;
                        rsp_next.status   = 1'b0;
                        rsp_next.where    = FIELD_W'(hit_idx_reg);
                        rsp_next.mark_out = req_reg.mark_in;
                        rsp_next.fill     = FIELD_W'(count_reg);
                        rsp_next.last     = 1'b0;
                    end
                    hit_valid_next = 1'b1;
                    hit_idx_next   = tag_reg;
                end
            end
            if (scan_issue)
            begin
                re            = 1'b1;
                raddr         = AW'(idx_reg);
                tag_next      = idx_reg;
                idx_next      = idx_reg + CW'(1);
                rd_valid_next = 1'b1;
            end
            else
            begin
                rd_valid_next = 1'b0;
            end
        end

        if (cmd.ins_step)
        begin
            if (rd_valid_reg)
            begin
                we    = 1'b1;
                waddr = AW'(tag_reg);
                wdata = rdata_reg;
            end
            if (ins_issue)
            begin
                re            = 1'b1;
                raddr         = AW'(idx_reg - CW'(1));
                tag_next      = idx_reg;
                idx_next      = idx_reg - CW'(1);
                rd_valid_next = 1'b1;
            end
            else
            begin
                rd_valid_next = 1'b0;
                if (!rd_valid_reg)
                begin
                    we         = 1'b1;
                    waddr      = AW'(req_reg.slot - FIELD_W'(1));
                    wdata      = req_reg.mark_in;
                    count_next = count_reg + CW'(1);
                end
            end
        end

        if (cmd.del_step)
        begin
            if (rd_valid_reg)
            begin
                we    = 1'b1;
                waddr = AW'(tag_reg);
                wdata = rdata_reg;
            end
            if (del_issue)
            begin
                re            = 1'b1;
                raddr         = AW'(idx_reg + CW'(1));
                tag_next      = idx_reg;
                idx_next      = idx_reg + CW'(1);
                rd_valid_next = 1'b1;
            end
            else
            begin
                rd_valid_next = 1'b0;
                if (!rd_valid_reg)
                begin
                    count_next = count_reg - CW'(1);
                end
            end
        end

        if (cmd.report && out_free)
        begin
            rsp_load          = 1'b1;
            rsp_next.fill     = FIELD_W'(count_reg);
            rsp_next.last     = 1'b1;
            rsp_next.mark_out = '0;
            rsp_next.where    = '0;
            rsp_next.status   = 1'b1;
            unique case (req_reg.req_type) inside
                REQ_SEARCH:
                begin
                    if (hit_valid_reg)
                    begin
                        rsp_next.status   = 1'b0;
                        rsp_next.where    = FIELD_W'(hit_idx_reg);
                        rsp_next.mark_out = req_reg.mark_in;
                    end
                end
                REQ_UPDATE, REQ_INSERT, REQ_DELETE:
                begin
                    rsp_next.status = !ok_reg;
                    rsp_next.where  = req_reg.slot;
                end
                default:
                begin
                    rsp_next.status = 1'b1;
                end
            endcase
        end

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req_in;
        end
        if (cmd.decide)
        begin
            ok_reg <= ok;
        end
        tag_reg     <= tag_next;
        hit_idx_reg <= hit_idx_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            hit_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= rd_valid_next;
            hit_valid_reg <= hit_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(count_reg) <= XW'(DEPTH))
        else $error("fill count above depth");

    a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.ins_step && !ins_issue && !rd_valid_reg)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("insert did not grow the count");

    a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.del_step && !del_issue && !rd_valid_reg)
        |=> count_reg == $past(count_reg) - CW'(1))
        else $error("delete did not shrink the count");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> tag_x < XW'(DEPTH))
        else $error("pending read tag out of range");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/pat_ctrl.sv -----
// Controller: request sequencing state machine.
`default_nettype none

module pat_ctrl
    import pat_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire pat_sts_t sts,
    output pat_cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_SCAN   = 6'b000100,
        S_INSERT = 6'b001000,
        S_DELETE = 6'b010000,
        S_REPORT = 6'b100000
    } pat_state_t;

    pat_state_t state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.capture = req_valid;
                if (req_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decide = 1'b1;
                unique case (sts.req_type)
                    REQ_DUMP:
                    begin
                        if (sts.empty)
                        begin
                            state_next = S_REPORT;
                        end
                        else
                        begin
                            cmd.start_scan = 1'b1;
                            state_next     = S_SCAN;
                        end
                    end
                    REQ_SEARCH:
                    begin
                        cmd.start_scan = 1'b1;
                        state_next     = S_SCAN;
                    end
                    REQ_UPDATE:
                    begin
                        cmd.write_upd = sts.ok;
                        state_next    = S_REPORT;
                    end
                    REQ_INSERT:
                    begin
                        cmd.start_ins = sts.ok;
                        state_next    = sts.ok ? S_INSERT : S_REPORT;
                    end
                    REQ_DELETE:
                    begin
                        cmd.start_del = sts.ok;
                        state_next    = sts.ok ? S_DELETE : S_REPORT;
                    end
                    default:
                    begin
                        state_next = S_REPORT;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = (sts.req_type == REQ_DUMP) ? S_IDLE : S_REPORT;
                end
            end
            S_INSERT:
            begin
                cmd.ins_step = 1'b1;
                if (sts.ins_done)
                begin
                    state_next = S_REPORT;
                end
            end
            S_DELETE:
            begin
                cmd.del_step = 1'b1;
                if (sts.del_done)
                begin
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                cmd.report = 1'b1;
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/positional_array_table.sv -----
// Update, rejected and empty dump requests go from accept through the decode state
// to the report state, which loads the response, then idle accepts the next request.
// Dump loads each entry in slot order as a response; search scans every entry, then reports.
// Insert and delete move m entries, one per cycle through a read and a write port, and
// respond from the report state. A stalled response holds the dump or search walk.
// Reset clears the fill count and control state; memory contents are not cleared.
`default_nettype none

module positional_array_table
    import pat_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    output logic          req_ready,
    input  wire pat_req_t req,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output pat_rsp_t      rsp
);

    pat_cmd_t cmd;
    pat_sts_t sts;

    pat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pat_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_in    (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// ----- bench/tb_positional_array_table.sv -----
// Self-checking testbench for the positional array table with a shadow predictor.
`default_nettype none

module tb_positional_array_table
    import pat_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_ITEMS = 325;
    localparam int PLAN_LEN     = 25;

    localparam logic [2:0] REQ_UNUSED5 = 3'd5;
    localparam logic [2:0] REQ_UNUSED7 = 3'd7;
    localparam logic       ST_DONE     = 1'b0;
    localparam logic       ST_REJECT   = 1'b1;
    localparam logic       BY_MODEL    = 1'b0;
    localparam logic       FIXED       = 1'b1;

    typedef struct packed {
        logic [2:0]         op;
        logic [FIELD_W-1:0] slot;
        logic [FIELD_W-1:0] mark;
        logic               typed;
        logic               status;
        logic [FIELD_W-1:0] where;
        logic [FIELD_W-1:0] fill;
    } plan_row_t;

    localparam plan_row_t PLAN [PLAN_LEN] = '{
        '{REQ_DUMP,    7'd0,   7'd0,   FIXED,    ST_REJECT, 7'd0,   7'd0},
        '{REQ_SEARCH,  7'd127, 7'd127, FIXED,    ST_REJECT, 7'd0,   7'd0},
        '{REQ_UPDATE,  7'd0,   7'd5,   FIXED,    ST_REJECT, 7'd0,   7'd0},
        '{REQ_DELETE,  7'd1,   7'd0,   FIXED,    ST_REJECT, 7'd1,   7'd0},
        '{REQ_INSERT,  7'd0,   7'd9,   FIXED,    ST_REJECT, 7'd0,   7'd0},
        '{REQ_INSERT,  7'd2,   7'd9,   FIXED,    ST_REJECT, 7'd2,   7'd0},
        '{REQ_INSERT,  7'd1,   7'd127, FIXED,    ST_DONE,   7'd1,   7'd1},
        '{REQ_INSERT,  7'd2,   7'd0,   FIXED,    ST_DONE,   7'd2,   7'd2},
        '{REQ_INSERT,  7'd1,   7'd85,  FIXED,    ST_DONE,   7'd1,   7'd3},
        '{REQ_INSERT,  7'd4,   7'd85,  FIXED,    ST_DONE,   7'd4,   7'd4},
        '{REQ_DUMP,    7'd0,   7'd0,   BY_MODEL, ST_DONE,   7'd0,   7'd0},
        '{REQ_SEARCH,  7'd0,   7'd85,  BY_MODEL, ST_DONE,   7'd0,   7'd0},
        '{REQ_SEARCH,  7'd0,   7'd42,  FIXED,    ST_REJECT, 7'd0,   7'd4},
        '{REQ_UPDATE,  7'd3,   7'd42,  FIXED,    ST_DONE,   7'd3,   7'd4},
        '{REQ_UPDATE,  7'd4,   7'd1,   FIXED,    ST_REJECT, 7'd4,   7'd4},
        '{REQ_UPDATE,  7'd127, 7'd127, FIXED,    ST_REJECT, 7'd127, 7'd4},
        '{REQ_INSERT,  7'd6,   7'd1,   FIXED,    ST_REJECT, 7'd6,   7'd4},
        '{REQ_INSERT,  7'd127, 7'd127, FIXED,    ST_REJECT, 7'd127, 7'd4},
        '{REQ_UNUSED5, 7'd3,   7'd3,   FIXED,    ST_REJECT, 7'd0,   7'd4},
        '{REQ_UNUSED7, 7'd127, 7'd127, FIXED,    ST_REJECT, 7'd0,   7'd4},
        '{REQ_DELETE,  7'd0,   7'd0,   FIXED,    ST_REJECT, 7'd0,   7'd4},
        '{REQ_DELETE,  7'd5,   7'd0,   FIXED,    ST_REJECT, 7'd5,   7'd4},
        '{REQ_DELETE,  7'd4,   7'd0,   FIXED,    ST_DONE,   7'd4,   7'd3},
        '{REQ_DELETE,  7'd1,   7'd0,   FIXED,    ST_DONE,   7'd1,   7'd2},
        '{REQ_SEARCH,  7'd0,   7'd0,   BY_MODEL, ST_DONE,   7'd0,   7'd0}
    };

    logic     clk;
    logic     rst_n;
    logic     req_valid;
    logic     req_ready;
    pat_req_t req;
    logic     rsp_valid;
    logic     rsp_ready;
    pat_rsp_t rsp;

    logic [FIELD_W-1:0] shadow_marks [TABLE_DEPTH];
    int                 shadow_fill;
    pat_rsp_t           step_rsp [$];
    pat_rsp_t           awaited_rsp [$];
    int                 errors;
    int                 send_idle;
    int                 recv_idle;
    bit                 growing;
    int                 full_visits;

    positional_array_table #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic pat_rsp_t make_rsp(input logic status, input int where,
                                          input logic [FIELD_W-1:0] mark, input logic last);
        pat_rsp_t r;
        r.status   = status;
        r.where    = FIELD_W'(where);
        r.mark_out = mark;
        r.fill     = FIELD_W'(shadow_fill);
        r.last     = last;
        return r;
    endfunction

    function automatic void predict_request(input pat_req_t r);
        int       slot;
        pat_rsp_t tail;
        slot = int'(r.slot);
        step_rsp.delete();
        case (r.req_type)
            REQ_DUMP:
            begin
                if (shadow_fill == 0)
                    step_rsp.push_back(make_rsp(ST_REJECT, 0, '0, 1'b1));
                for (int i = 0; i < shadow_fill; i++)
                    step_rsp.push_back(make_rsp(ST_DONE, i, shadow_marks[i],
                                                i == shadow_fill - 1));
            end
            REQ_SEARCH:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (shadow_marks[i] == r.mark_in)
                        step_rsp.push_back(make_rsp(ST_DONE, i, shadow_marks[i], 1'b0));
                if (step_rsp.size() == 0)
                    step_rsp.push_back(make_rsp(ST_REJECT, 0, '0, 1'b1));
                else
                begin
                    tail      = step_rsp.pop_back();
                    tail.last = 1'b1;
                    step_rsp.push_back(tail);
                end
            end
            REQ_UPDATE:
            begin
                if (slot < shadow_fill)
                begin
                    shadow_marks[slot] = r.mark_in;
                    step_rsp.push_back(make_rsp(ST_DONE, slot, '0, 1'b1));
                end
                else
                    step_rsp.push_back(make_rsp(ST_REJECT, slot, '0, 1'b1));
            end
            REQ_INSERT:
            begin
                if (shadow_fill >= TABLE_DEPTH || slot == 0 || slot > shadow_fill + 1)
                    step_rsp.push_back(make_rsp(ST_REJECT, slot, '0, 1'b1));
                else
                begin
                    for (int i = shadow_fill; i >= slot; i--)
                        shadow_marks[i] = shadow_marks[i-1];
                    shadow_marks[slot-1] = r.mark_in;
                    shadow_fill++;
                    step_rsp.push_back(make_rsp(ST_DONE, slot, '0, 1'b1));
                end
            end
            REQ_DELETE:
            begin
                if (shadow_fill == 0 || slot == 0 || slot > shadow_fill)
                    step_rsp.push_back(make_rsp(ST_REJECT, slot, '0, 1'b1));
                else
                begin
                    for (int i = slot - 1; i + 1 < shadow_fill; i++)
                        shadow_marks[i] = shadow_marks[i+1];
                    shadow_fill--;
                    step_rsp.push_back(make_rsp(ST_DONE, slot, '0, 1'b1));
                end
            end
            default:
                step_rsp.push_back(make_rsp(ST_REJECT, 0, '0, 1'b1));
        endcase
    endfunction

    function automatic pat_req_t random_request();
        pat_req_t r;
        int       roll;
        r.req_type = 3'($urandom_range(7));
        r.slot     = FIELD_W'($urandom_range(127));
        r.mark_in  = FIELD_W'($urandom_range(127));
        if ($urandom_range(99) < 8)
            return r;
        if (shadow_fill == TABLE_DEPTH)
            growing = 1'b0;
        else if (shadow_fill == 0)
            growing = 1'b1;
        roll = $urandom_range(99);
        if (roll < 60)
            r.req_type = growing ? REQ_INSERT : REQ_DELETE;
        else if (roll < 68)
            r.req_type = growing ? REQ_DELETE : REQ_INSERT;
        else if (roll < 80)
            r.req_type = REQ_UPDATE;
        else if (roll < 93)
            r.req_type = REQ_SEARCH;
        else
            r.req_type = REQ_DUMP;
        if (shadow_fill == TABLE_DEPTH && full_visits < 4)
        begin
            full_visits++;
            r.req_type = (full_visits == 2) ? REQ_DUMP : REQ_INSERT;
        end
        if ($urandom_range(1) == 0)
            r.mark_in = FIELD_W'($urandom_range(3));
        case (r.req_type)
            REQ_INSERT: r.slot = FIELD_W'($urandom_range(shadow_fill + 1, 1));
            REQ_DELETE: r.slot = FIELD_W'($urandom_range(shadow_fill > 0 ? shadow_fill : 1, 1));
            REQ_UPDATE: r.slot = FIELD_W'($urandom_range(shadow_fill > 0 ? shadow_fill - 1 : 0));
            REQ_SEARCH:
            begin
                if (shadow_fill > 0 && $urandom_range(1) == 1)
                    r.mark_in = shadow_marks[$urandom_range(shadow_fill - 1)];
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(input pat_req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic [FIELD_W-1:0] want,
                                input logic [FIELD_W-1:0] got);
        $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
        errors++;
    endtask

    task automatic check_response(input pat_rsp_t got);
        pat_rsp_t want;
        if (awaited_rsp.size() == 0)
        begin
            $display("%0t unexpected response: expected none actual %p", $time, got);
            errors++;
        end
        else
        begin
            want = awaited_rsp.pop_front();
            if (got.status !== want.status)
                report_field("status", FIELD_W'(want.status), FIELD_W'(got.status));
            if (got.where !== want.where)
                report_field("where", want.where, got.where);
            if (got.mark_out !== want.mark_out)
                report_field("mark_out", want.mark_out, got.mark_out);
            if (got.fill !== want.fill)
                report_field("fill", want.fill, got.fill);
            if (got.last !== want.last)
                report_field("last", FIELD_W'(want.last), FIELD_W'(got.last));
        end
    endtask

    initial
    begin
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && rsp_ready)
                check_response(rsp);
            rsp_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial
    begin
        pat_req_t rq;
        plan_row_t row;
        errors      = 0;
        shadow_fill = 0;
        growing     = 1'b1;
        full_visits = 0;
        send_idle   = 38;
        recv_idle   = 77;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        for (int k = 0; k < PLAN_LEN; k++)
        begin
            row = PLAN[k];
            rq.req_type = row.op;
            rq.slot     = row.slot;
            rq.mark_in  = row.mark;
            send_request(rq);
            predict_request(rq);
            if (row.typed)
                awaited_rsp.push_back('{row.status, row.where, '0, row.fill, 1'b1});
            else
                foreach (step_rsp[j])
                    awaited_rsp.push_back(step_rsp[j]);
        end
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                wait_drained();
                send_idle = 77;
                recv_idle = 38;
            end
            else if (n == 2 * RANDOM_ITEMS / 3)
            begin
                wait_drained();
                send_idle = 0;
                recv_idle = 0;
            end
            rq = random_request();
            send_request(rq);
            predict_request(rq);
            foreach (step_rsp[j])
                awaited_rsp.push_back(step_rsp[j]);
        end

        wait_drained();
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/pat_pkg.sv
rtl/core/pat_datapath.sv
rtl/core/pat_ctrl.sv
rtl/core/positional_array_table.sv
bench/tb_positional_array_table.sv
